@@ src/fptm_pkg.sv @@
`default_nettype none

package fptm_pkg;

    // refresh event codes, code seven is unused
    typedef enum logic [2:0] {
        OP_REFR_START   = 3'd0,
        OP_RENDER_START = 3'd1,
        OP_RENDER_READY = 3'd2,
        OP_WAIT_START   = 3'd3,
        OP_WAIT_FINISH  = 3'd4,
        OP_FLUSH_START  = 3'd5,
        OP_REFR_READY   = 3'd6
    } event_op_t;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef struct packed {
        event_op_t   operation;
        logic [63:0] time_us;
        logic [31:0] time_ms;
        logic        area_present;
        logic [15:0] area_width;
        logic [15:0] area_height;
    } event_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] stamp_ms;
        logic [31:0] total_span;
        logic [31:0] render_own;
        logic [31:0] wait_sum;
        logic [31:0] pixel_sum;
        logic [31:0] flush_sum;
    } report_t;

endpackage

`default_nettype wire

@@ src/fptm_in_reg.sv @@
`default_nettype none

module fptm_in_reg
    import fptm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   event_valid,
    output logic        event_ready,
    input  wire event_t event_data,
    input  wire logic   take,
    output logic        held_valid,
    output event_t      held_data
);

    logic   valid_reg;
    event_t data_reg;

    // refill in the same cycle the held event is consumed
    assign event_ready = !valid_reg || take;
    assign held_valid  = valid_reg;
    assign held_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (event_valid && event_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_valid && event_ready)
        begin
            data_reg <= event_data;
        end
    end

endmodule

`default_nettype wire

@@ src/fptm_accum.sv @@
`default_nettype none

module fptm_accum
    import fptm_pkg::*;
#(
    parameter int SPAN_WIDTH = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   take,
    input  wire event_t held_data,
    output logic        emit,
    output report_t     result
);

    logic                  drawing_reg, drawing_next;
    logic [SPAN_WIDTH-1:0] refr_start_reg, refr_start_next;
    logic [SPAN_WIDTH-1:0] render_start_reg, render_start_next;
    logic [SPAN_WIDTH-1:0] wait_start_reg, wait_start_next;
    logic [SPAN_WIDTH-1:0] render_span_reg, render_span_next;
    logic [SPAN_WIDTH-1:0] wait_total_reg, wait_total_next;
    logic [31:0]           pixel_total_reg, pixel_total_next;
    logic [31:0]           flush_count_reg, flush_count_next;

    logic [SPAN_WIDTH-1:0] now_us;
    logic [SPAN_WIDTH-1:0] total_span;
    logic [SPAN_WIDTH-1:0] render_own;
    logic [31:0]           strip_pixels;

    assign now_us       = held_data.time_us[SPAN_WIDTH-1:0];
    assign total_span   = now_us - refr_start_reg;
    assign render_own   = (render_span_reg > wait_total_reg) ?
                          (render_span_reg - wait_total_reg) : '0;
    assign strip_pixels = 32'(held_data.area_width) * 32'(held_data.area_height);

    function automatic logic [31:0] to_word(input logic [SPAN_WIDTH-1:0] v);
        logic [63:0] wide;
        wide    = 64'(v);
        to_word = wide[31:0];
    endfunction

    always_comb
    begin
        drawing_next      = drawing_reg;
        refr_start_next   = refr_start_reg;
        render_start_next = render_start_reg;
        wait_start_next   = wait_start_reg;
        render_span_next  = render_span_reg;
        wait_total_next   = wait_total_reg;
        pixel_total_next  = pixel_total_reg;
        flush_count_next  = flush_count_reg;
        emit              = 1'b0;
        result            = '0;
        result.stamp_ms   = held_data.time_ms;

        unique case (held_data.operation)
            OP_REFR_START:
            begin
                drawing_next       = 1'b0;
                render_span_next   = '0;
                wait_total_next    = '0;
                pixel_total_next   = '0;
                flush_count_next   = '0;
                refr_start_next    = now_us;
                emit               = 1'b1;
                result.result_kind = KIND_TICK;
            end
            OP_RENDER_START:
            begin
                drawing_next      = 1'b1;
                render_start_next = now_us;
            end
            OP_RENDER_READY:
            begin
                render_span_next = now_us - render_start_reg;
            end
            OP_WAIT_START:
            begin
                wait_start_next = now_us;
            end
            OP_WAIT_FINISH:
            begin
                wait_total_next = wait_total_reg + (now_us - wait_start_reg);
            end
            OP_FLUSH_START:
            begin
                if (held_data.area_present)
                begin
                    pixel_total_next = pixel_total_reg + strip_pixels;
                end
                flush_count_next = flush_count_reg + 32'd1;
            end
            OP_REFR_READY:
            begin
                // only a refresh that started rendering is reported
                if (drawing_reg)
                begin
                    drawing_next       = 1'b0;
                    emit               = 1'b1;
                    result.result_kind = KIND_FRAME;
                    result.total_span  = to_word(total_span);
                    result.render_own  = to_word(render_own);
                    result.wait_sum    = to_word(wait_total_reg);
                    result.pixel_sum   = pixel_total_reg;
                    result.flush_sum   = flush_count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drawing_reg      <= 1'b0;
            refr_start_reg   <= '0;
            render_start_reg <= '0;
            wait_start_reg   <= '0;
            render_span_reg  <= '0;
            wait_total_reg   <= '0;
            pixel_total_reg  <= '0;
            flush_count_reg  <= '0;
        end
        else if (take)
        begin
            drawing_reg      <= drawing_next;
            refr_start_reg   <= refr_start_next;
            render_start_reg <= render_start_next;
            wait_start_reg   <= wait_start_next;
            render_span_reg  <= render_span_next;
            wait_total_reg   <= wait_total_next;
            pixel_total_reg  <= pixel_total_next;
            flush_count_reg  <= flush_count_next;
        end
    end

`ifndef SYNTHESIS
    a_frame_needs_render: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && result.result_kind == KIND_FRAME) |-> drawing_reg)
        else $error("frame report without render start");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && held_data.operation == OP_REFR_START) |=>
        (flush_count_reg == '0 && pixel_total_reg == '0 && !drawing_reg))
        else $error("refresh start did not clear accumulators");

    a_report_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (take && emit && result.result_kind == KIND_FRAME) |=> !drawing_reg)
        else $error("drawing flag still set after frame report");
`endif

endmodule

`default_nettype wire

@@ src/fptm_out_reg.sv @@
`default_nettype none

module fptm_out_reg
    import fptm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    take,
    input  wire logic    emit,
    input  wire report_t result,
    output logic         free,
    output logic         report_valid,
    input  wire logic    report_ready,
    output report_t      report_data
);

    logic    valid_reg;
    report_t data_reg;

    assign free         = !valid_reg || report_ready;
    assign report_valid = valid_reg;
    assign report_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= emit;
        end
        else if (report_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

@@ src/frame_phase_timing_monitor_core.sv @@
`default_nettype none

// frame phase timing monitor: accepts one refresh event per cycle on the
// event channel and returns a clock tick for every refresh start and a frame
// report for every refresh ready that followed a render start. each event
// lands in an input register, the accumulators and the report fields are
// formed in one pass of logic (four subtracts, one 16x16 multiply-add, one
// compare) and the result sits in an output register. for an event that
// produces a report, report_valid rises at the clock edge that takes the
// held event out of the input register, and the sustained rate is one
// event per clock as long as report_ready keeps up. while a report waits
// unaccepted the held event waits too, whether or not it produces a
// report, and event_ready drops once the input register is full.
// SPAN_WIDTH sets the wrap width of the stored timestamps and spans; the
// reported fields are the low 32 bits of each span.

module frame_phase_timing_monitor_core
    import fptm_pkg::*;
#(
    parameter int SPAN_WIDTH = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   event_valid,
    output logic        event_ready,
    input  wire event_t event_data,
    output logic        report_valid,
    input  wire logic   report_ready,
    output report_t     report_data
);

    // held event and its consumption
    logic    held_valid;
    event_t  held_data;
    logic    take;
    logic    free;

    // per-event result before the output register
    logic    emit;
    report_t result;

    // an event is consumed once the output register can take its result
    assign take = held_valid && free;

    fptm_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_data  (event_data),
        .take        (take),
        .held_valid  (held_valid),
        .held_data   (held_data)
    );

    fptm_accum #(
        .SPAN_WIDTH (SPAN_WIDTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .held_data (held_data),
        .emit      (emit),
        .result    (result)
    );

    fptm_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .emit         (emit),
        .result       (result),
        .free         (free),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report_data  (report_data)
    );

endmodule

`default_nettype wire

@@ tb/sv/frame_phase_timing_monitor_core_tb.sv @@
`timescale 1ns / 100ps

module frame_phase_timing_monitor_core_tb;
    import fptm_pkg::*;

    // span wrap width of the block under test
    localparam int SPAN_W = 32;

    // event code seven has no meaning and must be dropped by the block
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // random stimulus size and run bounds
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 10;
    localparam int SHOWN_ERRORS = 10;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    event_valid;
    logic    event_ready;
    event_t  event_data;
    logic    report_valid;
    logic    report_ready;
    report_t report_data;

    frame_phase_timing_monitor_core #(
        .SPAN_WIDTH (SPAN_W)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_ready  (event_ready),
        .event_data   (event_data),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report_data  (report_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow copy of the frame timing state, all zero out of reset
    // ------------------------------------------------------------------
    logic              trk_drawing      = 1'b0;
    logic [63:0]       trk_refr_start   = '0;
    logic [63:0]       trk_render_start = '0;
    logic [63:0]       trk_wait_start   = '0;
    logic [SPAN_W-1:0] trk_render_span  = '0;
    logic [SPAN_W-1:0] trk_wait_total   = '0;
    logic [31:0]       trk_pixels       = '0;
    logic [31:0]       trk_flushes      = '0;

    // reports the block owes us, oldest first
    report_t pending_reports[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // when set, neither side inserts idle cycles
    bit calm = 1'b0;

    // receiver side knobs, owned by the ready process
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int phase_left   = 0;
    bit ready_phase  = 1'b0;

    // running timestamps for well formed frames
    logic [63:0] cur_us;
    logic [31:0] cur_ms;

    // mostly short idles, the odd long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic event_t mk_event(input logic [2:0] op, input logic [63:0] us,
                                        input logic [31:0] ms, input logic present,
                                        input logic [15:0] w, input logic [15:0] h);
        event_t ev;
        ev.operation    = event_op_t'(op);
        ev.time_us      = us;
        ev.time_ms      = ms;
        ev.area_present = present;
        ev.area_width   = w;
        ev.area_height  = h;
        return ev;
    endfunction

    // advance the tracked state by one accepted event and queue any report
    task automatic track_event(input event_t ev);
        report_t rep;
        rep          = '0;
        rep.stamp_ms = ev.time_ms;
        case (ev.operation)
            OP_REFR_START:
            begin
                // a new refresh wipes the accumulators and ticks
                trk_drawing     = 1'b0;
                trk_render_span = '0;
                trk_wait_total  = '0;
                trk_pixels      = '0;
                trk_flushes     = '0;
                trk_refr_start  = ev.time_us;
                rep.result_kind = KIND_TICK;
                pending_reports.push_back(rep);
            end
            OP_RENDER_START:
            begin
                trk_drawing      = 1'b1;
                trk_render_start = ev.time_us;
            end
            OP_RENDER_READY:
                trk_render_span = SPAN_W'(ev.time_us - trk_render_start);
            OP_WAIT_START:
                trk_wait_start = ev.time_us;
            OP_WAIT_FINISH:
                trk_wait_total = trk_wait_total + SPAN_W'(ev.time_us - trk_wait_start);
            OP_FLUSH_START:
            begin
                // a flush without area still counts as a flush
                if (ev.area_present)
                    trk_pixels = trk_pixels + 32'(ev.area_width) * 32'(ev.area_height);
                trk_flushes = trk_flushes + 32'd1;
            end
            OP_REFR_READY:
            begin
                // only a refresh that began rendering gets a report
                if (trk_drawing)
                begin
                    rep.result_kind = KIND_FRAME;
                    rep.total_span  = 32'(SPAN_W'(ev.time_us - trk_refr_start));
                    rep.render_own  = (trk_render_span > trk_wait_total)
                                      ? 32'(trk_render_span - trk_wait_total) : 32'd0;
                    rep.wait_sum    = 32'(trk_wait_total);
                    rep.pixel_sum   = trk_pixels;
                    rep.flush_sum   = trk_flushes;
                    trk_drawing     = 1'b0;
                    pending_reports.push_back(rep);
                end
            end
            default:
                ;
        endcase
    endtask

    // offer one event, hold it until the handshake, then update the shadow state.
    // must be entered right after a rising edge
    task automatic send_event(input event_t ev);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            event_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        event_valid <= 1'b1;
        event_data  <= ev;
        do
            @(posedge clk);
        while (!event_ready);
        track_event(ev);
        if (ev.operation != OP_UNUSED)
            items_sent++;
    endtask

    task automatic step_time();
        if ($urandom_range(0, 49) == 0)
            cur_us = {$urandom, $urandom};
        else
            cur_us = cur_us + $urandom_range(0, 5000);
        if ($urandom_range(0, 49) == 0)
            cur_ms = $urandom;
        else
            cur_ms = cur_ms + $urandom_range(0, 5);
    endtask

    task automatic send_timed(input logic [2:0] op);
        step_time();
        send_event(mk_event(op, cur_us, cur_ms, 1'b0, 16'($urandom), 16'($urandom)));
    endtask

    task automatic send_flush();
        step_time();
        send_event(mk_event(OP_FLUSH_START, cur_us, cur_ms, $urandom_range(0, 4) != 0,
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
    endtask

    task automatic send_noise();
        send_event(mk_event(3'($urandom_range(0, 7)), {$urandom, $urandom}, $urandom,
                            1'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    // one refresh in the usual order with random inner content. a missing render
    // start or a stray render ready or wait finish in the middle is rare but kept on purpose
    task automatic random_frame();
        int n_inner;
        int pick;
        send_timed(OP_REFR_START);
        if ($urandom_range(0, 9) != 0)
            send_timed(OP_RENDER_START);
        n_inner = $urandom_range(0, 6);
        for (int k = 0; k < n_inner; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                send_timed(OP_WAIT_START);
                send_timed(OP_WAIT_FINISH);
            end
            else if (pick < 8)
                send_flush();
            else if (pick < 9)
                send_timed(OP_RENDER_READY);
            else
                send_timed(OP_WAIT_FINISH);
        end
        if ($urandom_range(0, 9) != 0)
            send_timed(OP_RENDER_READY);
        send_timed(OP_REFR_READY);
    endtask

    // ------------------------------------------------------------------
    // receiver: random ready pattern, free running in calm stretches,
    // and a long counted hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            report_ready <= 1'b0;
        end
        else if (calm)
            report_ready <= 1'b1;
        else
        begin
            if (phase_left == 0)
            begin
                ready_phase = !ready_phase;
                phase_left  = ready_phase ? $urandom_range(1, 16) : idle_len() + 1;
            end
            phase_left   = phase_left - 1;
            report_ready <= ready_phase;
        end
    end

    // ------------------------------------------------------------------
    // report checker: each transaction against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : report_check
        report_t want;
        if (rst_n && report_valid && report_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                    $display("%0t: report with none outstanding: %h", $realtime, report_data);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(report_data.result_kind));
                check_field("stamp_ms", want.stamp_ms, report_data.stamp_ms);
                check_field("total_span", want.total_span, report_data.total_span);
                check_field("render_own", want.render_own, report_data.render_own);
                check_field("wait_sum", want.wait_sum, report_data.wait_sum);
                check_field("pixel_sum", want.pixel_sum, report_data.pixel_sum);
                check_field("flush_sum", want.flush_sum, report_data.flush_sum);
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** frame_phase_timing_monitor_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner cases straight out of reset, starting while every held time is still zero
    task automatic test_directed();
        // refresh ready with no render start: nothing comes out
        send_event(mk_event(OP_REFR_READY, 64'd5, 32'd1, 1'b0, 16'd0, 16'd0));
        // render ready and wait finish without their starts use the zero held times
        send_event(mk_event(OP_RENDER_READY, '1, 32'd2, 1'b1, '1, '1));
        send_event(mk_event(OP_WAIT_FINISH, 64'd123, 32'd3, 1'b0, 16'd0, 16'd0));
        // flush with no area only bumps the count
        send_event(mk_event(OP_FLUSH_START, 64'd200, 32'd4, 1'b0, '1, '1));
        send_event(mk_event(OP_UNUSED, '1, '1, 1'b1, '1, '1));
        send_event(mk_event(OP_FLUSH_START, 64'd300, 32'd5, 1'b1, '1, '1));
        // accumulators built outside any refresh still land in the report
        send_event(mk_event(OP_RENDER_START, 64'd100, 32'd6, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_REFR_READY, '1, '1, 1'b0, 16'd0, 16'd0));
        // a frame whose spans all wrap through zero
        send_event(mk_event(OP_REFR_START, '1, 32'd0, 1'b1, '1, '1));
        send_event(mk_event(OP_RENDER_START, 64'hFFFF_FFFF_FFFF_FFF0, 32'd7, 1'b0, 16'd0,
                            16'd0));
        send_event(mk_event(OP_WAIT_START, 64'hFFFF_FFFF_FFFF_FFF8, 32'd8, 1'b0, 16'd0,
                            16'd0));
        send_event(mk_event(OP_WAIT_FINISH, 64'd5, 32'd9, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_RENDER_READY, 64'd10, 32'd10, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_FLUSH_START, 64'd11, 32'd11, 1'b1, 16'd0, 16'd0));
        send_event(mk_event(OP_FLUSH_START, 64'd12, 32'd12, 1'b1, 16'd1, '1));
        send_event(mk_event(OP_REFR_READY, 64'd20, 32'hAAAA_5555, 1'b0, 16'd0, 16'd0));
        // waits longer than the render span clamp the render figure at zero
        send_event(mk_event(OP_REFR_START, 64'd900, 32'h5555_AAAA, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_RENDER_START, 64'd1000, 32'd13, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_WAIT_START, 64'd1000, 32'd14, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_WAIT_FINISH, 64'd1500, 32'd15, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_RENDER_READY, 64'd1200, 32'd16, 1'b0, 16'd0, 16'd0));
        send_event(mk_event(OP_REFR_READY, 64'd1600, 32'd17, 1'b0, 16'd0, 16'd0));
        // second ready in the same refresh finds drawing cleared
        send_event(mk_event(OP_REFR_READY, 64'd1700, 32'd18, 1'b0, 16'd0, 16'd0));
    endtask

    // mostly well formed refreshes with random content, some noise, some calm stretches
    task automatic test_random_frames();
        int goal;
        goal   = items_sent + RANDOM_ITEMS;
        cur_us = {$urandom, $urandom};
        cur_ms = $urandom;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            if ($urandom_range(0, 99) < 85)
                random_frame();
            else
                repeat ($urandom_range(1, 4)) send_noise();
        end
        calm = 1'b0;
    endtask

    // receiver holds off for a long stretch while events keep coming back to back
    task automatic test_backpressure();
        calm         = 1'b1;
        hold_request = 1'b1;
        repeat (15) random_frame();
        calm = 1'b0;
    endtask

    initial
    begin
        int drain_wait;
        rst_n        = 1'b0;
        event_valid  = 1'b0;
        event_data   = '0;
        report_ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_frames();
        test_backpressure();

        // wait for the last reports to come home
        event_valid <= 1'b0;
        drain_wait = 0;
        while (pending_reports.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            mismatch_count += pending_reports.size();
            $display("%0d expected reports never arrived", pending_reports.size());
        end

        if (mismatch_count == 0)
            $display("** frame_phase_timing_monitor_core: PASSED **");
        else
            $display("** frame_phase_timing_monitor_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
src/fptm_pkg.sv
src/fptm_in_reg.sv
src/fptm_accum.sv
src/fptm_out_reg.sv
src/frame_phase_timing_monitor_core.sv
tb/sv/frame_phase_timing_monitor_core_tb.sv
